// ----- hw/rtl/sv32ptw_pkg.sv -----
// ----------------------------------------------------------------------------
// sv32ptw_pkg
// Shared types and constants for the Sv32 page table walker.
// ----------------------------------------------------------------------------
package sv32ptw_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned PPN_W      = 22;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 22;

  // Page table entry flag positions
  localparam int unsigned PTE_V = 0;
  localparam int unsigned PTE_R = 1;
  localparam int unsigned PTE_X = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATION_ON   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE_NUMBER = 1'd1;

  // Input word selector
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_RESPONSE  = 1'b1;

  // Result word kind
  localparam logic KIND_READ_REQ = 1'b0;
  localparam logic KIND_DONE     = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_SV32    = 3'd1,
    ST_L1_INVALID  = 3'd2,
    ST_L0_INVALID  = 3'd3,
    ST_UNEXPECTED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT_L1 = 2'd1,
    PH_WAIT_L0 = 2'd2
  } phase_t;

  typedef struct packed {
    logic            kind;
    logic [XLEN-1:0] address;
    status_t         status;
    logic            superpage;
  } result_t;

endpackage

// ----- hw/rtl/sv32ptw_walk.sv -----
// ----------------------------------------------------------------------------
// sv32ptw_walk
// Walk state (phase, saved virtual address) and the one-step decode of an
// input word into a read request or a finished translation.
// ----------------------------------------------------------------------------
module sv32ptw_walk (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step_en,
  input  logic                                cmd,
  input  logic [sv32ptw_pkg::XLEN-1:0]        vaddr,
  input  logic [sv32ptw_pkg::XLEN-1:0]        pte,
  input  logic                                translation_on,
  input  logic [sv32ptw_pkg::PPN_W-1:0]       root_pn,
  output sv32ptw_pkg::result_t                res
);

  sv32ptw_pkg::phase_t            phase_r, phase_nxt;
  logic [sv32ptw_pkg::XLEN-1:0]   saved_va_r, saved_va_nxt;
  logic                           pte_valid;
  logic                           pte_leaf;
  logic                           walk_start;

  assign pte_valid  = pte[sv32ptw_pkg::PTE_V];
  assign pte_leaf   = pte[sv32ptw_pkg::PTE_R] | pte[sv32ptw_pkg::PTE_X];
  assign walk_start = (cmd == sv32ptw_pkg::CMD_TRANSLATE) &&
                      (phase_r == sv32ptw_pkg::PH_IDLE) && translation_on;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (cmd == sv32ptw_pkg::CMD_TRANSLATE) begin
      if (walk_start) begin
        phase_nxt = sv32ptw_pkg::PH_WAIT_L1;
      end
    end else begin
      unique case (phase_r)
        sv32ptw_pkg::PH_WAIT_L1: begin
          if (pte_valid && !pte_leaf) begin
            phase_nxt = sv32ptw_pkg::PH_WAIT_L0;
          end else begin
            phase_nxt = sv32ptw_pkg::PH_IDLE;
          end
        end
        sv32ptw_pkg::PH_WAIT_L0: phase_nxt = sv32ptw_pkg::PH_IDLE;
        default:                 phase_nxt = phase_r;
      endcase
    end
  end

  assign saved_va_nxt = walk_start ? vaddr : saved_va_r;

  // Result word
  always_comb begin
    res.kind      = sv32ptw_pkg::KIND_DONE;
    res.address   = '0;
    res.status    = sv32ptw_pkg::ST_UNEXPECTED;
    res.superpage = 1'b0;
    if (cmd == sv32ptw_pkg::CMD_TRANSLATE) begin
      if (phase_r != sv32ptw_pkg::PH_IDLE) begin
        res.status = sv32ptw_pkg::ST_UNEXPECTED;
      end else if (!translation_on) begin
        res.status = sv32ptw_pkg::ST_NOT_SV32;
      end else begin
        // Level one entry address: root table base plus VPN[1] * 4
        res.kind    = sv32ptw_pkg::KIND_READ_REQ;
        res.status  = sv32ptw_pkg::ST_OK;
        res.address = {root_pn[19:0], vaddr[31:22], 2'b00};
      end
    end else begin
      unique case (phase_r)
        sv32ptw_pkg::PH_WAIT_L1: begin
          if (!pte_valid) begin
            res.status = sv32ptw_pkg::ST_L1_INVALID;
          end else if (pte_leaf) begin
            res.status    = sv32ptw_pkg::ST_OK;
            res.superpage = 1'b1;
            res.address   = {pte[19:10], saved_va_r[21:0]};
          end else begin
            res.kind    = sv32ptw_pkg::KIND_READ_REQ;
            res.status  = sv32ptw_pkg::ST_OK;
            res.address = {pte[29:10], saved_va_r[21:12], 2'b00};
          end
        end
        sv32ptw_pkg::PH_WAIT_L0: begin
          if (!pte_valid) begin
            res.status = sv32ptw_pkg::ST_L0_INVALID;
          end else begin
            res.status  = sv32ptw_pkg::ST_OK;
            res.address = {pte[29:10], saved_va_r[11:0]};
          end
        end
        default: res.status = sv32ptw_pkg::ST_UNEXPECTED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sv32ptw_pkg::PH_IDLE;
      saved_va_r <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      saved_va_r <= saved_va_nxt;
    end
  end

  // Level zero is reached only from level one
  a_l0_from_l1: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sv32ptw_pkg::PH_WAIT_L0) && ($past(phase_r) != sv32ptw_pkg::PH_WAIT_L0)
    |-> $past(phase_r) == sv32ptw_pkg::PH_WAIT_L1)
    else $error("walk entered level zero wait without level one");

  // Saved address changes only when a walk starts
  a_va_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(saved_va_r) |-> $past(step_en && walk_start))
    else $error("saved virtual address changed outside a walk start");

  // A walk start always issues a read request
  a_start_reads: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && walk_start |-> res.kind == sv32ptw_pkg::KIND_READ_REQ)
    else $error("walk start did not issue a read request");

endmodule

// ----- hw/rtl/sv32_page_table_walker_unit.sv -----
// ----------------------------------------------------------------------------
// sv32_page_table_walker_unit
// Two-level Sv32 page table walker with stream input and result channels.
// ----------------------------------------------------------------------------
// Each input word is either a translate command (in_tuser = 0, virtual
// address in in_tdata[31:0]) or a memory read response (in_tuser = 1, page
// table entry in in_tdata[63:32]). Every input word yields exactly one result
// word: a read request for the next table entry (out_tuser = 0) or a finished
// translation (out_tuser = 1) with a status and a superpage flag. The block
// takes one word per clock while the result stream is not stalled; a word
// accepted is captured in the input register and decoded combinationally, and
// its result word is loaded into the result register once that register is
// free (one input register, one result register, one decode step). A stalled
// result register holds the input stage. Memory latency lives outside, between
// a read request and the response fed back in. Words that do not fit the
// current walk phase return status unexpected and leave the walk untouched.
// Configuration is written through cfg_we/cfg_idx/cfg_wdata while idle:
// index 0 = translation enable, index 1 = root page number.
// ----------------------------------------------------------------------------
module sv32_page_table_walker_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Configuration write port
  input  logic                                   cfg_we,
  input  logic [sv32ptw_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [sv32ptw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [sv32ptw_pkg::IN_DATA_W-1:0]      in_tdata,  // [31:0] virtual_address,
                                                            // [63:32] entry_word
  input  logic                                   in_tuser,  // [0] cmd
  // Result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [sv32ptw_pkg::OUT_DATA_W-1:0]     out_tdata, // [31:0] address,
                                                            // [34:32] status,
                                                            // [35] superpage,
                                                            // [39:36] zero
  output logic                                   out_tuser  // [0] kind
);

  // Configuration registers
  logic                               trans_on_r;
  logic [sv32ptw_pkg::PPN_W-1:0]      root_pn_r;

  // Input register stage
  logic                               s1_valid_r, s1_valid_nxt;
  logic                               s1_cmd_r;
  logic [sv32ptw_pkg::XLEN-1:0]       s1_va_r;
  logic [sv32ptw_pkg::XLEN-1:0]       s1_pte_r;

  // Result register stage
  logic                               out_valid_r, out_valid_nxt;
  sv32ptw_pkg::result_t               out_res_r;
  sv32ptw_pkg::result_t               step_res;

  logic                               in_fire;
  logic                               out_load;
  logic                               s1_fire;

  // The result register can take a new word when empty or being drained
  assign out_load  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // Config write: hold the value until the next write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_on_r <= 1'b0;
      root_pn_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sv32ptw_pkg::CFG_TRANSLATION_ON:   trans_on_r <= cfg_wdata[0];
        sv32ptw_pkg::CFG_ROOT_PAGE_NUMBER: root_pn_r  <= cfg_wdata;
        default:                           root_pn_r  <= root_pn_r;
      endcase
    end
  end

  // Input register: capture the word on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_tuser;
      s1_va_r  <= in_tdata[31:0];
      s1_pte_r <= in_tdata[63:32];
    end
  end

  // Walk step: advances the walk state when the word moves on
  sv32ptw_walk u_walk (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (s1_fire),
    .cmd            (s1_cmd_r),
    .vaddr          (s1_va_r),
    .pte            (s1_pte_r),
    .translation_on (trans_on_r),
    .root_pn        (root_pn_r),
    .res            (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {4'b0000, out_res_r.superpage, out_res_r.status, out_res_r.address};

  // A read request always carries status ok and no superpage flag
  a_req_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == sv32ptw_pkg::KIND_READ_REQ)
    |-> (out_res_r.status == sv32ptw_pkg::ST_OK) && !out_res_r.superpage)
    else $error("read request with bad status or superpage");

  // Error results carry a zero address
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status != sv32ptw_pkg::ST_OK)
    |-> (out_res_r.address == '0) && (out_res_r.kind == sv32ptw_pkg::KIND_DONE))
    else $error("error result with nonzero address");

  // A word in the input stage moves on whenever the result stage frees up
  a_no_stall_loss: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_load |=> out_valid_r)
    else $error("input stage word was not moved to result register");

endmodule
